// ===== hw/rtl/jlsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jlsr_pkg
// Shared types and constants for the jerk-limited speed ramp.
// ----------------------------------------------------------------------------
package jlsr_pkg;
	localparam int FRAC_BITS = 16;
	localparam int SPD_W = 24;
	localparam int REG_W = 23;
	localparam int DT_W = 16;
	localparam int ADDR_W = 5;

	localparam logic [ADDR_W-1:0] ADDR_SPEED_LIMIT = 5'd0;
	localparam logic [ADDR_W-1:0] ADDR_ACCEL_CEIL  = 5'd4;
	localparam logic [ADDR_W-1:0] ADDR_ACCEL_REQ   = 5'd8;
	localparam logic [ADDR_W-1:0] ADDR_DECEL       = 5'd12;
	localparam logic [ADDR_W-1:0] ADDR_JERK        = 5'd16;

	typedef struct packed {
		logic [REG_W-1:0] speed_limit;
		logic [REG_W-1:0] accel_ceiling;
		logic [REG_W-1:0] accel_request;
		logic [REG_W-1:0] decel_limit;
		logic [REG_W-1:0] jerk_limit;
	} cfg_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;    // capture input beat
		logic step_a;  // jerk step product, speed error and acceleration square
		logic step_b;  // release test product and limit selection
		logic step_c;  // acceleration slew
		logic step_d;  // speed change product
		logic step_e;  // final speed and state commit
	} cmd_t;
endpackage

// ===== hw/rtl/jlsr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jlsr_in_if / jlsr_out_if
// Valid/ready channels for tick items and results.
// ----------------------------------------------------------------------------
interface jlsr_in_if;
	logic valid;
	logic ready;
	logic signed [23:0] target_speed;
	logic [15:0] dt;
	logic force_zero;
	modport source (output valid, target_speed, dt, force_zero, input ready);
	modport sink (input valid, target_speed, dt, force_zero, output ready);
endinterface

interface jlsr_out_if;
	logic valid;
	logic ready;
	logic signed [23:0] speed;
	logic signed [23:0] acceleration;
	modport source (output valid, speed, acceleration, input ready);
	modport sink (input valid, speed, acceleration, output ready);
endinterface

// ===== hw/rtl/jlsr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jlsr_ctrl
// Sequencer: accepts a beat, steps the datapath, presents the result.
// ----------------------------------------------------------------------------
module jlsr_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output jlsr_pkg::cmd_t cmd
);
	import jlsr_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_A    = 3'd1;
	localparam logic [2:0] S_B    = 3'd2;
	localparam logic [2:0] S_C    = 3'd3;
	localparam logic [2:0] S_D    = 3'd4;
	localparam logic [2:0] S_E    = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0] state_q;

	// Next beat is taken once the result register is free or being drained.
	assign out_valid = (state_q == S_OUT);
	assign in_ready = (state_q == S_IDLE) || (state_q == S_OUT && out_ready);

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && in_ready;
		cmd.step_a = (state_q == S_A);
		cmd.step_b = (state_q == S_B);
		cmd.step_c = (state_q == S_C);
		cmd.step_d = (state_q == S_D);
		cmd.step_e = (state_q == S_E);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_A;
				S_A: state_q <= S_B;
				S_B: state_q <= S_C;
				S_C: state_q <= S_D;
				S_D: state_q <= S_E;
				S_E: state_q <= S_OUT;
				S_OUT: begin
					if (out_ready) state_q <= in_valid ? S_A : S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== hw/rtl/jlsr_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jlsr_dp
// Datapath: speed and acceleration state, products spread over the steps.
// ----------------------------------------------------------------------------
module jlsr_dp (
	input  logic clk,
	input  logic arst_n,
	input  jlsr_pkg::cfg_t cfg,
	input  jlsr_pkg::cmd_t cmd,
	input  logic signed [23:0] target_speed,
	input  logic [15:0] dt,
	input  logic force_zero,
	output logic signed [23:0] speed,
	output logic signed [23:0] acceleration
);
	import jlsr_pkg::*;

	logic signed [SPD_W-1:0] cur_q, acc_q;
	logic rel_q;
	logic signed [SPD_W:0] tgt_q;
	logic [DT_W-1:0] dt_q;
	logic fz_q;
	logic signed [SPD_W+1:0] err_q;
	logic [REG_W+DT_W-FRAC_BITS:0] jstep_q;
	logic [2*SPD_W-1:0] asq_q;
	logic [REG_W:0] alim_q;
	logic [REG_W+SPD_W+1:0] jerr_q;
	logic signed [SPD_W:0] nacc_q;
	logic nrel_q;
	logic [SPD_W+DT_W-FRAC_BITS-1:0] am_q;

	logic signed [SPD_W:0] lim_s, tcl;
	logic [SPD_W:0] mag_t, mag_c, mag_e, mag_a;
	logic [REG_W:0] areq;
	logic use_dec, do_rel, rel_c;
	logic signed [SPD_W+1:0] desired, goal, accw;
	logic signed [SPD_W+1:0] stepw;
	logic signed [SPD_W+2:0] nxt, dv;

	assign lim_s = $signed({2'b00, cfg.speed_limit});
	assign mag_t = tgt_q[SPD_W] ? -tgt_q : tgt_q;
	assign mag_c = cur_q[SPD_W-1] ? -{cur_q[SPD_W-1], cur_q} : {cur_q[SPD_W-1], cur_q};
	assign mag_e = err_q[SPD_W+1] ? (SPD_W+1)'(0) - err_q[SPD_W:0] : err_q[SPD_W:0];
	assign mag_a = nacc_q[SPD_W] ? -nacc_q : nacc_q;

	always_comb begin
		tcl = {target_speed[SPD_W-1], target_speed};
		if (tcl > lim_s) tcl = lim_s;
		else if (tcl < -lim_s) tcl = -lim_s;
	end

	always_comb begin
		areq = (cfg.accel_request == '0 || cfg.accel_request > cfg.accel_ceiling)
			? {1'b0, cfg.accel_ceiling} : {1'b0, cfg.accel_request};
		use_dec = (tgt_q == '0) || (cur_q > 0 && tgt_q < 0) || (cur_q < 0 && tgt_q > 0)
			|| (mag_t < mag_c);
	end

	// Pick the goal from the step B limit and the release test, slew toward it, then clear release at zero.
	always_comb begin
		desired = err_q > 0 ? $signed({2'b00, alim_q}) : -$signed({2'b00, alim_q});
		do_rel = 1'b0;
		if (err_q == 0) begin
			goal = '0;
		end else if (rel_q) begin
			goal = '0;
		end else if (((acc_q > 0 && err_q > 0) || (acc_q < 0 && err_q < 0))
			&& jerr_q <= {2'b00, asq_q}) begin
			goal = '0;
			do_rel = 1'b1;
		end else begin
			goal = desired;
		end
		stepw = $signed({2'b00, jstep_q});
		accw = {{2{acc_q[SPD_W-1]}}, acc_q};
		if (accw < goal) begin
			accw = accw + stepw;
			if (accw > goal) accw = goal;
		end else if (accw > goal) begin
			accw = accw - stepw;
			if (accw < goal) accw = goal;
		end
		rel_c = (rel_q || do_rel) && (accw != 0);
		if (err_q == 0) rel_c = rel_q && (accw != 0);
	end

	always_comb begin
		dv = nacc_q[SPD_W] ? -$signed({3'b000, am_q}) : $signed({3'b000, am_q});
		nxt = $signed({{3{cur_q[SPD_W-1]}}, cur_q}) + dv;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tgt_q <= tcl;
			dt_q <= dt;
			fz_q <= force_zero;
		end
		if (cmd.step_a) begin
			jstep_q <= (REG_W+DT_W-FRAC_BITS+1)'(({{DT_W{1'b0}}, cfg.jerk_limit}
				* {{REG_W{1'b0}}, dt_q}) >> FRAC_BITS);
			err_q <= {tgt_q[SPD_W], tgt_q} - {{2{cur_q[SPD_W-1]}}, cur_q};
			asq_q <= acc_q * acc_q;
		end
		if (cmd.step_b) begin
			jerr_q <= {cfg.jerk_limit, 1'b0} * mag_e;
			alim_q <= use_dec ? {1'b0, cfg.decel_limit} : areq;
		end
		if (cmd.step_c) begin
			nacc_q <= accw[SPD_W:0];
			nrel_q <= rel_c;
		end
		if (cmd.step_d) begin
			am_q <= (SPD_W+DT_W-FRAC_BITS)'(({{DT_W{1'b0}}, mag_a}
				* {{(SPD_W+1){1'b0}}, dt_q}) >> FRAC_BITS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			acc_q <= '0;
			rel_q <= 1'b0;
		end else if (cmd.step_e) begin
			if (fz_q) begin
				cur_q <= '0;
				acc_q <= '0;
				rel_q <= 1'b0;
			end else if (dt_q != '0) begin
				acc_q <= nacc_q[SPD_W-1:0];
				if (err_q == 0) begin
					cur_q <= tgt_q[SPD_W-1:0];
					rel_q <= nrel_q;
				end else if ((err_q > 0 && nxt >= tgt_q) || (err_q < 0 && nxt <= tgt_q)) begin
					cur_q <= tgt_q[SPD_W-1:0];
					rel_q <= nrel_q || (nacc_q != 0);
				end else begin
					rel_q <= nrel_q;
					if (nxt > 27'sd8388607) cur_q <= 24'sh7FFFFF;
					else if (nxt < -27'sd8388608) cur_q <= 24'sh800000;
					else cur_q <= nxt[SPD_W-1:0];
				end
			end
		end
	end

	assign speed = cur_q;
	assign acceleration = acc_q;
endmodule

// ===== hw/rtl/jlsr_apb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jlsr_apb
// Configuration register file behind an APB-style port.
// ----------------------------------------------------------------------------
module jlsr_apb (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [jlsr_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output jlsr_pkg::cfg_t cfg
);
	import jlsr_pkg::*;

	cfg_t cfg_q;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speed_limit <= 23'd131072;
			cfg_q.accel_ceiling <= 23'd131072;
			cfg_q.accel_request <= 23'd0;
			cfg_q.decel_limit <= 23'd196608;
			cfg_q.jerk_limit <= 23'd655360;
		end else if (psel && penable && pwrite) begin
			unique case (paddr)
				ADDR_SPEED_LIMIT: cfg_q.speed_limit <= pwdata[REG_W-1:0];
				ADDR_ACCEL_CEIL: cfg_q.accel_ceiling <= pwdata[REG_W-1:0];
				ADDR_ACCEL_REQ: cfg_q.accel_request <= pwdata[REG_W-1:0];
				ADDR_DECEL: cfg_q.decel_limit <= pwdata[REG_W-1:0];
				ADDR_JERK: cfg_q.jerk_limit <= pwdata[REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			ADDR_SPEED_LIMIT: prdata = {9'd0, cfg_q.speed_limit};
			ADDR_ACCEL_CEIL: prdata = {9'd0, cfg_q.accel_ceiling};
			ADDR_ACCEL_REQ: prdata = {9'd0, cfg_q.accel_request};
			ADDR_DECEL: prdata = {9'd0, cfg_q.decel_limit};
			ADDR_JERK: prdata = {9'd0, cfg_q.jerk_limit};
			default: prdata = '0;
		endcase
	end
endmodule

// ===== hw/rtl/jerk_limited_speed_ramp_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jerk_limited_speed_ramp_unit
// S-curve speed ramp: one control tick in, one speed/acceleration beat out.
// ----------------------------------------------------------------------------
//  channel   | dir | carries
//  tick_in   | in  | target_speed, dt, force_zero
//  ramp_out  | out | speed, acceleration
//  apb       | in  | five 23-bit limit registers at 0x00..0x10
//
// A tick passes through the five sequencer steps A to E before its result
// is valid. A new tick is taken in the cycle its predecessor's result is
// taken, so a tick is never accepted while another is still in progress.
// Reset clears speed, acceleration and the release flag; a stalled result
// simply holds.
module jerk_limited_speed_ramp_unit (
	input  logic clk,
	input  logic arst_n,
	jlsr_in_if.sink tick_in,
	jlsr_out_if.source ramp_out,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [jlsr_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import jlsr_pkg::*;

	cfg_t cfg;
	cmd_t cmd;

	jlsr_apb u_apb (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .cfg
	);

	jlsr_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(tick_in.valid), .in_ready(tick_in.ready),
		.out_valid(ramp_out.valid), .out_ready(ramp_out.ready),
		.cmd
	);

	jlsr_dp u_dp (
		.clk, .arst_n, .cfg, .cmd,
		.target_speed(tick_in.target_speed), .dt(tick_in.dt),
		.force_zero(tick_in.force_zero),
		.speed(ramp_out.speed), .acceleration(ramp_out.acceleration)
	);
endmodule

// ===== hw/rtl/jlsr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jlsr_checker
// Port-level checks for the speed ramp unit.
// ----------------------------------------------------------------------------
module jlsr_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [23:0] speed,
	input logic pready
);
	// A result can never be waiting while the unit is idle for input.
	a_no_ready_while_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready) else $error("ready while result held");
	// An accepted tick does not produce a result in the next cycle.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid) else $error("result too early");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(speed)) else $error("result dropped");
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
endmodule

bind jerk_limited_speed_ramp_unit jlsr_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(tick_in.valid), .in_ready(tick_in.ready),
	.out_valid(ramp_out.valid), .out_ready(ramp_out.ready),
	.speed(ramp_out.speed), .pready(pready)
);

// ===== verif/tb_jerk_limited_speed_ramp_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_jerk_limited_speed_ramp_unit
// Drives control ticks through the jerk-limited speed ramp under several
// limit settings and handshake idling patterns. A behavioral predictor of
// the S-curve ramp computes each expected speed/acceleration beat, and a
// monitor compares every output beat field by field.
// ----------------------------------------------------------------------------
module tb_jerk_limited_speed_ramp_unit;
	import jlsr_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic signed [SPD_W-1:0] speed;
		logic signed [SPD_W-1:0] acceleration;
	} ramp_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	jlsr_in_if tick_in ();
	jlsr_out_if ramp_out ();

	jerk_limited_speed_ramp_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.tick_in(tick_in.sink),
		.ramp_out(ramp_out.source),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #4 clk = ~clk;

	// Predictor state and register shadow.
	longint m_speed_limit, m_accel_ceil, m_accel_req, m_decel, m_jerk;
	longint m_speed, m_accel;
	bit m_releasing;

	ramp_beat_t expected_beats[$];
	int fail_count = 0;
	int idle_cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_off = 1'b0;

	initial begin
		tick_in.valid = 1'b0;
		tick_in.target_speed = '0;
		tick_in.dt = '0;
		tick_in.force_zero = 1'b0;
		ramp_out.ready = 1'b0;
	end

	function automatic longint slew_toward(longint v, longint goal, longint step);
		if (v < goal) begin
			v += step;
			if (v > goal)
				v = goal;
		end else if (v > goal) begin
			v -= step;
			if (v < goal)
				v = goal;
		end
		return v;
	endfunction

	function automatic longint magnitude(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic ramp_beat_t advance_ramp(longint target, longint dt, bit fz);
		longint step, err, alim, desired, am, dv, nxt, cur, acc;
		ramp_beat_t beat;
		cur = m_speed;
		acc = m_accel;
		if (target > m_speed_limit)
			target = m_speed_limit;
		else if (target < -m_speed_limit)
			target = -m_speed_limit;
		if (fz) begin
			m_speed = 0;
			m_accel = 0;
			m_releasing = 1'b0;
		end else if (dt != 0) begin
			step = (m_jerk * dt) >>> FRAC_BITS;
			err = target - cur;
			if (err == 0) begin
				acc = slew_toward(acc, 0, step);
				if (acc == 0)
					m_releasing = 1'b0;
				m_speed = target;
				m_accel = acc;
			end else begin
				alim = (m_accel_req == 0 || m_accel_req > m_accel_ceil) ?
					m_accel_ceil : m_accel_req;
				if (target == 0 || (cur > 0 && target < 0) || (cur < 0 && target > 0) ||
						magnitude(target) < magnitude(cur))
					alim = m_decel;
				desired = err > 0 ? alim : -alim;
				if (m_releasing) begin
					desired = 0;
				end else if (((acc > 0 && err > 0) || (acc < 0 && err < 0)) &&
						2 * m_jerk * magnitude(err) <= acc * acc) begin
					m_releasing = 1'b1;
					desired = 0;
				end
				acc = slew_toward(acc, desired, step);
				if (m_releasing && acc == 0)
					m_releasing = 1'b0;
				am = (magnitude(acc) * dt) >>> FRAC_BITS;
				dv = acc < 0 ? -am : am;
				nxt = cur + dv;
				if ((err > 0 && nxt >= target) || (err < 0 && nxt <= target)) begin
					nxt = target;
					if (acc != 0)
						m_releasing = 1'b1;
				end else if (nxt > 8388607) begin
					nxt = 8388607;
				end else if (nxt < -8388608) begin
					nxt = -8388608;
				end
				m_speed = nxt;
				m_accel = acc;
			end
		end
		beat.speed = m_speed[SPD_W-1:0];
		beat.acceleration = m_accel[SPD_W-1:0];
		return beat;
	endfunction

	task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [REG_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {9'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (addr)
			ADDR_SPEED_LIMIT: m_speed_limit = value;
			ADDR_ACCEL_CEIL: m_accel_ceil = value;
			ADDR_ACCEL_REQ: m_accel_req = value;
			ADDR_DECEL: m_decel = value;
			ADDR_JERK: m_jerk = value;
			default: ;
		endcase
	endtask

	task automatic set_limits(input logic [REG_W-1:0] spd, ceil, req, dec, jerk);
		write_reg(ADDR_SPEED_LIMIT, spd);
		write_reg(ADDR_ACCEL_CEIL, ceil);
		write_reg(ADDR_ACCEL_REQ, req);
		write_reg(ADDR_DECEL, dec);
		write_reg(ADDR_JERK, jerk);
	endtask

	// Sends one tick; the expectation is computed when the beat is taken.
	// Valid stays high on return so that ticks can follow back to back; the
	// next idle gap or wait_idle drops it.
	task automatic send_tick(input logic signed [23:0] target, input logic [15:0] dt,
			input logic fz);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			tick_in.valid <= 1'b0;
			@(negedge clk);
		end
		tick_in.valid <= 1'b1;
		tick_in.target_speed <= target;
		tick_in.dt <= dt;
		tick_in.force_zero <= fz;
		@(posedge clk);
		while (!tick_in.ready)
			@(posedge clk);
		expected_beats.push_back(advance_ramp(target, dt, fz));
		@(negedge clk);
	endtask

	task automatic wait_idle();
		tick_in.valid <= 1'b0;
		while (expected_beats.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Mostly well-formed ramps: a target held for a run of ticks with sensible dt.
	task automatic random_ticks(input int count);
		logic signed [23:0] target;
		int run;
		int sent;
		sent = 0;
		while (sent < count) begin
			target = $urandom_range(9) == 0 ? $signed(24'($urandom())) :
				$signed(24'($urandom_range(0, 32'(2 * m_speed_limit + 2)))) -
				$signed(24'(m_speed_limit + 1));
			run = $urandom_range(1, 30);
			repeat (run) begin
				case ($urandom_range(19))
					0: send_tick(24'($urandom()), 16'($urandom()), 1'b1);
					1: send_tick(target, 16'd0, 1'b0);
					2: send_tick(target, 16'($urandom()), 1'b0);
					default: send_tick(target, 16'($urandom_range(1, 3000)), 1'b0);
				endcase
				sent++;
			end
		end
	endtask

	task automatic test_directed();
		send_tick(24'sd100000, 16'd655, 1'b0);
		send_tick(24'sd100000, 16'd0, 1'b0);
		repeat (6) send_tick(24'sd100000, 16'd6554, 1'b0);
		send_tick(24'sd100000, 16'hFFFF, 1'b0);
		send_tick(24'sd100000, 16'hFFFF, 1'b0);
		send_tick(24'sd50000, 16'd6554, 1'b0);
		send_tick(-24'sd8388608, 16'd6554, 1'b0);
		send_tick(-24'sd8388608, 16'hFFFF, 1'b0);
		send_tick(24'sd0, 16'd6554, 1'b0);
		send_tick(24'sd8388607, 16'd1, 1'b0);
		send_tick(24'sd8388607, 16'hFFFF, 1'b1);
		send_tick(24'sd8388607, 16'hFFFF, 1'b0);
		send_tick(-24'sd1, 16'd32768, 1'b0);
		send_tick(24'sd0, 16'd0, 1'b1);
	endtask

	task automatic test_extreme_limits();
		set_limits(23'h7FFFFF, 23'h7FFFFF, 23'd0, 23'h7FFFFF, 23'h7FFFFF);
		send_tick(24'sd8388607, 16'hFFFF, 1'b0);
		send_tick(24'sd8388607, 16'hFFFF, 1'b0);
		send_tick(-24'sd8388608, 16'hFFFF, 1'b0);
		send_tick(-24'sd8388608, 16'hFFFF, 1'b0);
		send_tick(24'sd0, 16'hFFFF, 1'b1);
		random_ticks(60);
		wait_idle();
		set_limits(23'd0, 23'd1, 23'h7FFFFF, 23'd1, 23'd1);
		random_ticks(40);
		wait_idle();
		// Request below the ceiling is honored.
		set_limits(23'd262144, 23'd200000, 23'd65536, 23'd131072, 23'd300000);
		random_ticks(100);
		wait_idle();
	endtask

	task automatic test_idling();
		set_limits(23'd131072, 23'd131072, 23'd0, 23'd196608, 23'd655360);
		send_tick(24'sd0, 16'd0, 1'b1);
		send_idle_pct = 70;
		random_ticks(250);
		send_idle_pct = 0;
		recv_stall_pct = 70;
		random_ticks(250);
		send_idle_pct = 8;
		recv_stall_pct = 8;
		random_ticks(250);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		wait_idle();
	endtask

	task automatic test_backpressure();
		hold_off = 1'b1;
		fork
			begin
				repeat (300) @(negedge clk);
				hold_off = 1'b0;
			end
			random_ticks(20);
		join
		wait_idle();
	endtask

	task automatic test_random_settings();
		repeat (4) begin
			set_limits(REG_W'($urandom_range(0, 23'h7FFFFF) >> $urandom_range(0, 8)),
				REG_W'($urandom_range(1, 23'h7FFFFF) >> $urandom_range(0, 8)),
				REG_W'($urandom_range(0, 23'h7FFFFF) >> $urandom_range(0, 12)),
				REG_W'($urandom_range(1, 23'h7FFFFF) >> $urandom_range(0, 8)),
				REG_W'($urandom_range(1, 23'h7FFFFF) >> $urandom_range(0, 6)));
			send_tick(24'sd0, 16'd0, 1'b1);
			random_ticks(90);
			wait_idle();
		end
	endtask

	// Result readiness, changed at the falling edge.
	always @(negedge clk) begin
		if (hold_off)
			ramp_out.ready <= 1'b0;
		else
			ramp_out.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		ramp_beat_t exp_beat;
		if (tick_in.valid && tick_in.ready || ramp_out.valid && ramp_out.ready)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t watchdog: no beat accepted in %0d cycles", $time, WATCHDOG_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
		if (arst_n && ramp_out.valid && ramp_out.ready) begin
			if (expected_beats.size() == 0) begin
				$display("%0t unexpected beat: speed %0d accel %0d", $time,
					ramp_out.speed, ramp_out.acceleration);
				fail_count++;
			end else begin
				exp_beat = expected_beats.pop_front();
				if (ramp_out.speed !== exp_beat.speed) begin
					$display("%0t speed mismatch: expected %0d actual %0d", $time,
						exp_beat.speed, ramp_out.speed);
					fail_count++;
				end
				if (ramp_out.acceleration !== exp_beat.acceleration) begin
					$display("%0t acceleration mismatch: expected %0d actual %0d", $time,
						exp_beat.acceleration, ramp_out.acceleration);
					fail_count++;
				end
			end
		end
	end

	initial begin
		m_speed_limit = 131072;
		m_accel_ceil = 131072;
		m_accel_req = 0;
		m_decel = 196608;
		m_jerk = 655360;
		m_speed = 0;
		m_accel = 0;
		m_releasing = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		wait_idle();
		test_extreme_limits();
		test_idling();
		test_backpressure();
		test_random_settings();
		if (expected_beats.size() != 0) begin
			$display("%0t %0d expected beats never arrived", $time, expected_beats.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
